@@ sv/sldg_pkg.sv @@
// Shared types and constants of the seasonal logistic diffusion grid step.
`default_nettype none
package sldg_pkg;

  localparam int DATA_W = 24;
  localparam int GAIN_W = 24;
  localparam int MONTH_W = 4;
  localparam int KIND_W = 2;
  localparam int SCALE_W = 17;
  localparam int SIDE_W = 6;
  localparam int MA_W = 33;
  localparam int MB_W = 25;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W = 59;
  localparam int LAP_W = 28;
  localparam int SQ_W = 32;
  localparam int V_W = 40;
  localparam int T_W = 41;

  localparam logic [DATA_W-1:0] SAT24 = 24'hFFFFFF;
  localparam logic [SCALE_W-1:0] DEEP_PLOW_Q16 = 17'd32768;
  localparam logic [SCALE_W-1:0] SHALLOW_PLOW_Q16 = 17'd52429;
  localparam logic [SCALE_W-1:0] POISON_Q16 = 17'd13107;

  localparam logic [MONTH_W-1:0] MONTH_SUMMER = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_SHALLOW = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_POISON = 4'd3;

  typedef enum logic [KIND_W-1:0] {
    MEASURE_NONE    = 2'd0,
    MEASURE_SHALLOW = 2'd1,
    MEASURE_DEEP    = 2'd2,
    MEASURE_POISON  = 2'd3
  } measure_t;

  typedef enum logic [2:0] {
    REG_FERTILITY = 3'd0,
    REG_MORTALITY = 3'd1,
    REG_MIGRATION = 3'd2,
    REG_MONTH     = 3'd3,
    REG_MEASURE   = 3'd4,
    REG_WINTER    = 3'd5,
    REG_SIDE      = 3'd6,
    REG_NONE      = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_CEN, S_LEFT, S_RIGHT, S_MSQ, S_MF, S_MM,
    S_MG, S_ACC, S_V, S_S1, S_S2, S_S3, S_OUT, S_FIN
  } state_t;

endpackage
`default_nettype wire

@@ sv/seasonal_logistic_diffusion_grid_step.sv @@
// Top level: line store, sequencer and shared multiplier for the grid update.
// A first-row item is written to the line store and gives no result.
// Any other item raises its result after a sequence of four store reads and up to six passes
// through one multiplier, the last two of them only with a season scale.
// A new item is accepted only after the last result of the item before is taken; the frame's
// last item adds a further result per cell of the last row.
// Reset clears the counters, the sequencer and the output valid and loads register
// defaults; the line store is not cleared.
`default_nettype none
module seasonal_logistic_diffusion_grid_step
  import sldg_pkg::*;
#(
  parameter int GRID_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [DATA_W-1:0]  cell_density,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [DATA_W-1:0]  new_density,
  output logic                    frame_end,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int CNT_W = $clog2(GRID_WIDTH + 1);
  localparam int AW = XW + 1;
  localparam int DEPTH = 2 ** AW;

  logic [GAIN_W-1:0]  fertility_gain;
  logic [GAIN_W-1:0]  mortality_gain;
  logic [GAIN_W-1:0]  migration_gain;
  logic [MONTH_W-1:0] month_number;
  logic [KIND_W-1:0]  measure_kind;
  logic [SCALE_W-1:0] winter_gain;
  logic [SIDE_W-1:0]  side_length;

  state_t state, state_next;

  logic [CNT_W-1:0] col, row, x, y, n;
  logic [XW-1:0] ex;
  logic hc, f_up, f_dn, f_l, f_r, flush;
  logic [DATA_W-1:0] d, s, up_val;
  logic signed [LAP_W-1:0] lap;
  logic [SQ_W-1:0] sq;
  logic signed [ACC_W-1:0] acc;
  logic [V_W-1:0] v;
  logic [T_W-1:0] t;
  logic [SCALE_W-1:0] m;
  logic scale_on;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] p;

  logic accept, out_take, cfg_wr;
  logic [CNT_W-1:0] xw, yw;
  logic [ACC_W-1:0] vv;
  logic [PROD_W-1:0] tot;
  logic [PROD_W-17:0] sv;
  logic signed [LAP_W-1:0] left_term, right_term, up_term, dn_term;
  logic last_cell, flush_last;
  reg_index_t cfg_sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_sel = reg_index_t'(paddr[4:2]);
  assign accept = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (side_length < SIDE_W'(2)) begin
      n = CNT_W'(2);
    end else if ({1'b0, side_length} > (SIDE_W + 1)'(GRID_WIDTH)) begin
      n = CNT_W'(GRID_WIDTH);
    end else begin
      n = CNT_W'(side_length);
    end
  end

  assign xw = (col >= n) ? '0 : col;
  assign yw = (row >= n) ? '0 : row;

  always_comb begin
    scale_on = 1'b0;
    m = winter_gain;
    if (month_number > MONTH_SUMMER) begin
      scale_on = 1'b1;
    end else if (month_number == MONTH_SUMMER && measure_kind == MEASURE_DEEP) begin
      scale_on = 1'b1;
      m = DEEP_PLOW_Q16;
    end else if (month_number == MONTH_SHALLOW && measure_kind == MEASURE_SHALLOW) begin
      scale_on = 1'b1;
      m = SHALLOW_PLOW_Q16;
    end else if (month_number == MONTH_POISON && measure_kind == MEASURE_POISON) begin
      scale_on = 1'b1;
      m = POISON_Q16;
    end
  end

  assign left_term = f_l ? (LAP_W'({1'b0, rdata}) - LAP_W'({1'b0, s})) : '0;
  assign right_term = f_r ? (LAP_W'({1'b0, rdata}) - LAP_W'({1'b0, s})) : '0;
  assign up_term = f_up ? (LAP_W'({1'b0, up_val}) - LAP_W'({1'b0, s})) : '0;
  assign dn_term = f_dn ? (LAP_W'({1'b0, d}) - LAP_W'({1'b0, s})) : '0;

  assign vv = ACC_W'(acc >>> 16);
  assign tot = (PROD_W'(p[32:0]) << 24) + PROD_W'(t);
  assign sv = tot[PROD_W-1:16];
  assign last_cell = (x + CNT_W'(1) == n) && (y + CNT_W'(1) == n);
  assign flush_last = (CNT_W'(ex) + CNT_W'(1) == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = {y[0], x[XW-1:0]};
    raddr = {~hc, ex};
    mul_a = {{(MA_W - DATA_W){1'b0}}, s};
    mul_b = {1'b0, s};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UP;
        end
      end
      S_UP: begin
        raddr = {~hc, ex};
        state_next = S_CEN;
      end
      S_CEN: begin
        raddr = {hc, ex};
        we = !flush;
        state_next = (!flush && y == '0) ? S_FIN : S_LEFT;
      end
      S_LEFT: begin
        raddr = {hc, ex - XW'(1)};
        state_next = S_RIGHT;
      end
      S_RIGHT: begin
        raddr = {hc, ex + XW'(1)};
        state_next = S_MSQ;
      end
      S_MSQ: begin
        state_next = S_MF;
      end
      S_MF: begin
        mul_a = {{(MA_W - GAIN_W){fertility_gain[GAIN_W-1]}}, fertility_gain};
        state_next = S_MM;
      end
      S_MM: begin
        mul_a = {1'b0, sq};
        mul_b = {mortality_gain[GAIN_W-1], mortality_gain};
        state_next = S_MG;
      end
      S_MG: begin
        mul_a = {{(MA_W - LAP_W){lap[LAP_W-1]}}, lap};
        mul_b = {migration_gain[GAIN_W-1], migration_gain};
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = S_V;
      end
      S_V: begin
        if (acc[ACC_W-1] || acc == '0 || !scale_on) begin
          state_next = S_OUT;
        end else begin
          state_next = S_S1;
        end
      end
      S_S1: begin
        mul_a = {{(MA_W - 24){1'b0}}, v[23:0]};
        mul_b = {{(MB_W - SCALE_W){1'b0}}, m};
        state_next = S_S2;
      end
      S_S2: begin
        mul_a = {{(MA_W - 16){1'b0}}, v[V_W-1:24]};
        mul_b = {{(MB_W - SCALE_W){1'b0}}, m};
        state_next = S_S3;
      end
      S_S3: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_take) begin
          if (flush) begin
            state_next = flush_last ? S_FIN : S_UP;
          end else begin
            state_next = last_cell ? S_UP : S_FIN;
          end
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      out_valid <= 1'b0;
      flush <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x <= xw;
            y <= yw;
            d <= cell_density;
            ex <= xw[XW-1:0];
            hc <= ~yw[0];
            f_up <= (yw > CNT_W'(1));
            f_dn <= 1'b1;
            f_l <= (xw != '0);
            f_r <= (xw + CNT_W'(1) < n);
            flush <= 1'b0;
          end
        end
        S_CEN: up_val <= rdata;
        S_LEFT: s <= rdata;
        S_RIGHT: lap <= left_term;
        S_MSQ: begin
          lap <= lap + right_term;
          acc <= ACC_W'({s, 16'b0});
        end
        S_MF: begin
          sq <= p[47:16];
          lap <= lap + up_term;
        end
        S_MM: begin
          if (month_number < MONTH_SUMMER) begin
            acc <= acc + ACC_W'(p);
          end
          lap <= lap + dn_term;
        end
        S_MG: acc <= acc + ACC_W'(p);
        S_ACC: acc <= acc + ACC_W'(p);
        S_V: begin
          v <= vv[V_W-1:0];
          if (acc[ACC_W-1] || acc == '0) begin
            new_density <= '0;
            out_valid <= 1'b1;
          end else if (!scale_on) begin
            new_density <= (vv > ACC_W'(SAT24)) ? SAT24 : vv[DATA_W-1:0];
            out_valid <= 1'b1;
          end
          frame_end <= flush && flush_last;
        end
        S_S2: t <= p[T_W-1:0];
        S_S3: begin
          new_density <= (sv > (PROD_W - 16)'(SAT24)) ? SAT24 : sv[DATA_W-1:0];
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (flush) begin
              ex <= ex + XW'(1);
              f_l <= 1'b1;
              f_r <= (CNT_W'(ex) + CNT_W'(2) < n);
            end else if (last_cell) begin
              flush <= 1'b1;
              ex <= '0;
              hc <= y[0];
              f_up <= 1'b1;
              f_dn <= 1'b0;
              f_l <= 1'b0;
              f_r <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (x + CNT_W'(1) >= n) begin
            col <= '0;
            row <= (y + CNT_W'(1) >= n) ? '0 : y + CNT_W'(1);
          end else begin
            col <= x + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fertility_gain <= '0;
      mortality_gain <= '0;
      migration_gain <= '0;
      month_number <= 4'd3;
      measure_kind <= MEASURE_NONE;
      winter_gain <= 17'd55706;
      side_length <= 6'd32;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FERTILITY: fertility_gain <= pwdata[GAIN_W-1:0];
        REG_MORTALITY: mortality_gain <= pwdata[GAIN_W-1:0];
        REG_MIGRATION: migration_gain <= pwdata[GAIN_W-1:0];
        REG_MONTH:     month_number <= pwdata[MONTH_W-1:0];
        REG_MEASURE:   measure_kind <= pwdata[KIND_W-1:0];
        REG_WINTER:    winter_gain <= pwdata[SCALE_W-1:0];
        REG_SIDE:      side_length <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FERTILITY: prdata = 32'(fertility_gain);
      REG_MORTALITY: prdata = 32'(mortality_gain);
      REG_MIGRATION: prdata = 32'(migration_gain);
      REG_MONTH:     prdata = 32'(month_number);
      REG_MEASURE:   prdata = 32'(measure_kind);
      REG_WINTER:    prdata = 32'(winter_gain);
      REG_SIDE:      prdata = 32'(side_length);
      default:       prdata = '0;
    endcase
  end

  sldg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(d),
    .raddr(raddr),
    .rdata(rdata)
  );

  sldg_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (p)
  );

endmodule
`default_nettype wire

@@ sv/sldg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sldg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/sldg_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module sldg_mul
  import sldg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MA_W-1:0]   a,
  input  wire logic signed [MB_W-1:0]   b,
  output logic signed      [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ tb/tb_seasonal_logistic_diffusion_grid_step.sv @@
// Self-checking testbench for the seasonal logistic diffusion grid step.
`timescale 1ns / 1ps
module tb_seasonal_logistic_diffusion_grid_step;
  import sldg_pkg::*;

  localparam int GW = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 30;

  typedef struct {
    logic [DATA_W-1:0] density;
    logic              fend;
  } cell_result_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, frame_end;
  logic [DATA_W-1:0] cell_density, new_density;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  seasonal_logistic_diffusion_grid_step #(.GRID_WIDTH(GW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cell_density(cell_density),
    .out_valid(out_valid), .out_stall(out_stall), .new_density(new_density),
    .frame_end(frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register mirror
  logic signed [GAIN_W-1:0] fert_g, mort_g, migr_g;
  logic [MONTH_W-1:0] month_r;
  logic [KIND_W-1:0] measure_r;
  logic [SCALE_W-1:0] winter_r;
  logic [SIDE_W-1:0] side_r;

  logic [DATA_W-1:0] grid_rows [2][GW];
  int col_cnt, row_cnt;

  logic [DATA_W-1:0] pending_cells[$];
  cell_result_t expected_cells[$];

  int send_idle, recv_idle;
  int cells_in, results_out, mismatches, phases, idle_cycles, hold_left;
  bit held;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] scale_q16(logic [DATA_W-1:0] v_in,
                                                  logic [SCALE_W-1:0] m);
    longint unsigned v;
    v = (longint'(v_in) * longint'(m)) >> 16;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] next_density(logic [DATA_W-1:0] s,
                                                     longint nsum, int ncnt);
    longint sv, sq, lap, acc;
    longint unsigned v;
    sv = longint'(s);
    sq = (sv * sv) >>> 16;
    lap = nsum - longint'(ncnt) * sv;
    acc = sv * 65536 + longint'(mort_g) * sq + longint'(migr_g) * lap;
    if (month_r < MONTH_SUMMER) acc += longint'(fert_g) * sv;
    if (acc <= 0) return '0;
    v = longint'(acc) >> 16;
    if (month_r > MONTH_SUMMER) v = (v * longint'(winter_r)) >> 16;
    if (month_r == MONTH_SUMMER && measure_r == MEASURE_DEEP)
      v = (v * longint'(DEEP_PLOW_Q16)) >> 16;
    if (month_r == MONTH_SHALLOW && measure_r == MEASURE_SHALLOW)
      v = (v * longint'(SHALLOW_PLOW_Q16)) >> 16;
    if (month_r == MONTH_POISON && measure_r == MEASURE_POISON)
      v = (v * longint'(POISON_Q16)) >> 16;
    return (v > longint'(SAT24)) ? SAT24 : v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] cell_update(int x, int r, int n,
                                                    logic [DATA_W-1:0] up,
                                                    logic [DATA_W-1:0] down);
    longint sum;
    int cnt;
    sum = 0;
    cnt = 0;
    if (x > 0) begin sum += grid_rows[r & 1][x-1]; cnt++; end
    if (x + 1 < n) begin sum += grid_rows[r & 1][x+1]; cnt++; end
    if (r > 0) begin sum += up; cnt++; end
    if (r + 1 < n) begin sum += down; cnt++; end
    return next_density(grid_rows[r & 1][x], sum, cnt);
  endfunction

  task automatic take_cell(logic [DATA_W-1:0] d);
    int n, x, y;
    logic [DATA_W-1:0] old;
    cell_result_t c;
    n = side_r < 2 ? 2 : (side_r > GW ? GW : int'(side_r));
    if (col_cnt >= n) col_cnt = 0;
    if (row_cnt >= n) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    old = grid_rows[y & 1][x];
    grid_rows[y & 1][x] = d;
    if (y > 0) begin
      c.density = cell_update(x, y - 1, n, old, d);
      c.fend = 1'b0;
      expected_cells.push_back(c);
    end
    if (x + 1 == n && y + 1 == n) begin
      for (int i = 0; i < n; i++) begin
        c.density = cell_update(i, y, n, grid_rows[(y - 1) & 1][i], '0);
        c.fend = (i + 1 == n);
        expected_cells.push_back(c);
      end
    end
    col_cnt = x + 1;
    if (col_cnt >= n) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= n) row_cnt = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_cell(cell_density);
        cells_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          cell_density <= pending_cells.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_result_t c;
    if (!rst && out_valid && !out_stall) begin
      results_out++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: density %h frame_end %b", new_density, frame_end);
      end else begin
        c = expected_cells.pop_front();
        if (c.density !== new_density || c.fend !== frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %h/%b, got %h/%b",
                     results_out, c.density, c.fend, new_density, frame_end);
        end
      end
    end
    if (!held && results_out == 60) begin
      held = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FERTILITY: fert_g = val[GAIN_W-1:0];
      REG_MORTALITY: mort_g = val[GAIN_W-1:0];
      REG_MIGRATION: migr_g = val[GAIN_W-1:0];
      REG_MONTH:     month_r = val[MONTH_W-1:0];
      REG_MEASURE:   measure_r = val[KIND_W-1:0];
      REG_WINTER:    winter_r = val[SCALE_W-1:0];
      REG_SIDE:      side_r = val[SIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_cells.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_all(int f, int m, int g, int mon, measure_t k, int w, int s);
    reg_write(REG_FERTILITY, f);
    reg_write(REG_MORTALITY, m);
    reg_write(REG_MIGRATION, g);
    reg_write(REG_MONTH, mon);
    reg_write(REG_MEASURE, k);
    reg_write(REG_WINTER, w);
    reg_write(REG_SIDE, s);
    phases++;
  endtask

  function automatic logic [DATA_W-1:0] rand_density();
    case ($urandom_range(3))
      0: return $urandom_range(24'hFFFFFF);
      1: return $urandom_range(2) == 0 ? 24'hFFFFFF : 24'h0;
      default: return $urandom_range(24'h3FFFF);
    endcase
  endfunction

  function automatic int rand_gain(int lo, int hi);
    case ($urandom_range(9))
      0: return -8388608;
      1: return 8388607;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  initial begin
    int n, frames;
    rst = 1'b1;
    in_valid = 1'b0;
    cell_density = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 29;
    recv_idle = 49;
    fert_g = '0; mort_g = '0; migr_g = '0;
    month_r = 4'd3; measure_r = MEASURE_NONE; winter_r = 17'd55706; side_r = 6'd32;
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < GW; c++) grid_rows[r][c] = '0;
    col_cnt = 0; row_cnt = 0;
    cells_in = 0; results_out = 0; mismatches = 0; phases = 0;
    idle_cycles = 0; hold_left = 0; held = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // side below minimum, poison in spring, full growth
    set_all(8388607, 0, 0, 3, MEASURE_POISON, 55706, 0);
    pending_cells = '{24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h1};
    drain();
    // side of one, summer deep plow, strong migration
    set_all(0, -8388608, 8388607, 7, MEASURE_DEEP, 0, 1);
    pending_cells = '{24'hFFFFFF, 24'h0, 24'h800000, 24'hFFFFFF};
    drain();
    // shallow plow, negative gains
    set_all(-8388608, -8388608, -8388608, 2, MEASURE_SHALLOW, 65536, 3);
    pending_cells = '{24'h0, 24'hFFFFFF, 24'h10000, 24'h555555, 24'hAAAAAA,
                      24'h1, 24'h8000, 24'hFFFFFF, 24'h0};
    drain();
    // winter with full survival, no measure
    set_all(30000, -100, 16384, 12, MEASURE_NONE, 65536, 2);
    pending_cells = '{24'h20000, 24'h18000, 24'hFFFFFF, 24'h7FFFFF};
    drain();
    // oversized side acts as built width; change side after three rows
    set_all(-20000, -300, 8000, 5, MEASURE_NONE, 55706, 63);
    for (int i = 0; i < 3 * GW; i++) pending_cells.push_back(rand_density());
    drain();
    reg_write(REG_SIDE, 3);
    for (int i = 0; i < 9; i++) pending_cells.push_back(rand_density());
    drain();

    while (cells_in < 520) begin
      if (cells_in > 350) begin
        send_idle <= 0;
        recv_idle <= 0;
      end else if (cells_in > 180) begin
        send_idle <= 49;
        recv_idle <= 29;
      end
      case ($urandom_range(9))
        0: n = 8 + $urandom_range(4);
        1: n = $urandom_range(1);
        default: n = 2 + $urandom_range(4);
      endcase
      set_all(rand_gain(-65536, 65536), rand_gain(-4096, 0), rand_gain(-8192, 32768),
              $urandom_range(15), measure_t'($urandom_range(3)),
              $urandom_range(2) == 0 ? ($urandom_range(1) ? 65536 : 0)
                                     : $urandom_range(65536), n);
      if (n < 2) n = 2;
      frames = 1 + $urandom_range(2);
      for (int i = 0; i < frames * n * n; i++) pending_cells.push_back(rand_density());
      drain();
    end

    $display("%0d cells in %0d register settings, %0d results checked",
             cells_in, phases, results_out);
    $display("sides 2..12 and clamped extremes, all months and measures, long output stall");
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_cells.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
